// ===== design/stp_pkg.sv =====
// Package for the telemetry receiver: constants, shared types and the
// fixed-point conversion function. No dependencies.
`timescale 1ns / 1ps

package stp_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

    localparam logic [7:0]  START_BYTE = 8'h7E;
    localparam logic [7:0]  STUFF_BYTE = 8'h7D;
    localparam logic [7:0]  STUFF_XOR  = 8'h20;
    localparam logic [7:0]  PRIM_DATA  = 8'h10;
    localparam logic [7:0]  SUM_GOOD   = 8'hFF;

    localparam logic [3:0]  IDX_PRIM   = 4'd1;
    localparam logic [3:0]  IDX_APP_LO = 4'd2;
    localparam logic [3:0]  IDX_APP_HI = 4'd3;
    localparam logic [3:0]  IDX_D0     = 4'd4;
    localparam logic [3:0]  IDX_D1     = 4'd5;
    localparam logic [3:0]  IDX_D2     = 4'd6;
    localparam logic [3:0]  IDX_D3     = 4'd7;

    localparam logic [7:0]  HUB_ALT     = 8'h01;
    localparam logic [7:0]  HUB_STATUS  = 8'h05;
    localparam logic [7:0]  HUB_LON_DM  = 8'h12;
    localparam logic [7:0]  HUB_LAT_DM  = 8'h13;
    localparam logic [7:0]  HUB_LON_FR  = 8'h1A;
    localparam logic [7:0]  HUB_LAT_FR  = 8'h1B;
    localparam logic [7:0]  HUB_EW      = 8'h22;
    localparam logic [7:0]  HUB_NS      = 8'h23;

    localparam logic [11:0] APP_T2_HI   = 12'h041;
    localparam logic [11:0] APP_ALT_HI  = 12'h082;
    localparam logic [11:0] APP_POS_HI  = 12'h080;

    localparam logic [15:0] CODE_N = 16'h004E;
    localparam logic [15:0] CODE_S = 16'h0053;
    localparam logic [15:0] CODE_E = 16'h0045;
    localparam logic [15:0] CODE_W = 16'h0057;

    localparam logic [1:0]  HEMI_N = 2'd0;
    localparam logic [1:0]  HEMI_S = 2'd1;
    localparam logic [1:0]  HEMI_E = 2'd2;

    localparam logic [13:0] DIV_10    = 14'd10;
    localparam logic [13:0] DIV_60    = 14'd60;
    localparam logic [13:0] DIV_100   = 14'd100;
    localparam logic [13:0] DIV_10000 = 14'd10000;

    localparam logic [16:0] DEG_SCALE = 17'd100000;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_IN,
        PH_XOR
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIX,
        ST_WAIT
    } dec_state_t;

    typedef enum logic [2:0] {
        OP_ST100,
        OP_ST10,
        OP_PK10K,
        OP_PK60,
        OP_LAT100,
        OP_LAT60,
        OP_LON100,
        OP_LON60
    } div_op_t;

    typedef struct packed {
        logic        ok;
        logic [7:0]  prim;
        logic [15:0] app;
        logic [31:0] data;
    } frame_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [13:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [13:0] remainder;
    } div_rsp_t;

    function automatic logic [26:0] to_fixed(input logic positive, input logic [9:0] whole,
                                             input logic [31:0] part);
        logic [26:0] v;
        v = 27'(whole * DEG_SCALE) + part[26:0];
        return positive ? v : 27'(27'd0 - v);
    endfunction

endpackage

// ===== design/stp_deframer.sv =====
// Front end: start detection, byte unstuffing, frame capture and running
// checksum. Depends on stp_pkg.
`timescale 1ns / 1ps

module stp_deframer import stp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    output logic       push,
    output frame_t     frame
);

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       prim_reg;
    logic [15:0]      app_reg;
    logic [31:0]      data_reg;
    logic             store;
    logic [7:0]       value;
    logic [8:0]       sum_wide;
    logic [7:0]       sum_fold;

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        store      = 1'b0;
        value      = byte_data;
        push       = 1'b0;
        if (byte_valid) begin
            if (byte_data == START_BYTE) begin
                phase_next = PH_IN;
                count_next = '0;
                sum_next   = '0;
            end else begin
                unique case (phase_reg)
                    PH_XOR: begin
                        store      = 1'b1;
                        value      = byte_data ^ STUFF_XOR;
                        phase_next = PH_IN;
                    end
                    PH_IN: begin
                        if (byte_data == STUFF_BYTE) begin
                            phase_next = PH_XOR;
                        end else begin
                            store = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
        sum_wide = {1'b0, sum_reg} + {1'b0, value};
        sum_fold = sum_wide[7:0] + {7'd0, sum_wide[8]};
        if (store) begin
            if (count_reg != '0) begin
                sum_next = sum_fold;
            end
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_W'(FRAME_BYTES - 1)) begin
                push       = 1'b1;
                phase_next = PH_IDLE;
                count_next = '0;
            end
        end
        frame.ok   = (sum_fold == SUM_GOOD);
        frame.prim = prim_reg;
        frame.app  = app_reg;
        frame.data = data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            sum_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store) begin
            unique case (4'(count_reg))
                IDX_PRIM:   prim_reg        <= value;
                IDX_APP_LO: app_reg[7:0]    <= value;
                IDX_APP_HI: app_reg[15:8]   <= value;
                IDX_D0:     data_reg[7:0]   <= value;
                IDX_D1:     data_reg[15:8]  <= value;
                IDX_D2:     data_reg[23:16] <= value;
                IDX_D3:     data_reg[31:24] <= value;
                default: ;
            endcase
        end
    end

endmodule

// ===== design/stp_frame_fifo.sv =====
// Two-entry queue of captured frames between front end and decoder.
// Depends on stp_pkg.
`timescale 1ns / 1ps

module stp_frame_fifo import stp_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  frame_t push_frame,
    input  logic   pop,
    output frame_t head,
    output logic   empty,
    output logic   full
);

    frame_t     entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_frame;
    end

endmodule

// ===== design/stp_divider.sv =====
// Shared divider by the constants 10, 60, 100 and 10000: reciprocal
// multiplication; registers product, quotient, remainder. Depends on stp_pkg.
`timescale 1ns / 1ps

module stp_divider import stp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam logic [31:0] RECIP_60    = 32'h8888_8889;
    localparam logic [31:0] RECIP_100   = 32'h51EB_851F;
    localparam logic [31:0] RECIP_10000 = 32'hD1B7_1759;
    localparam logic [5:0]  SHIFT_10    = 6'd35;
    localparam logic [5:0]  SHIFT_60    = 6'd37;
    localparam logic [5:0]  SHIFT_100   = 6'd37;
    localparam logic [5:0]  SHIFT_10000 = 6'd45;

    logic        mul_stage_reg, sub_stage_reg, done_reg;
    logic [63:0] prod_reg;
    logic [5:0]  shift_reg;
    logic [13:0] low_reg;
    logic [13:0] div_reg;
    logic [31:0] quo_reg;
    logic [13:0] rem_reg;
    logic [31:0] recip;
    logic [5:0]  shift;

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    always_comb begin
        unique case (req.divisor)
            DIV_10: begin
                recip = RECIP_10;
                shift = SHIFT_10;
            end
            DIV_60: begin
                recip = RECIP_60;
                shift = SHIFT_60;
            end
            DIV_100: begin
                recip = RECIP_100;
                shift = SHIFT_100;
            end
            DIV_10000: begin
                recip = RECIP_10000;
                shift = SHIFT_10000;
            end
            default: begin
                recip = '0;
                shift = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_stage_reg <= 1'b0;
            sub_stage_reg <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            mul_stage_reg <= req.start;
            sub_stage_reg <= mul_stage_reg;
            done_reg      <= sub_stage_reg;
        end
    end

    // remainder is below 2^14, so the low bits of the dividend suffice
    always_ff @(posedge aclk) begin
        if (req.start) begin
            prod_reg  <= 64'(req.dividend) * 64'(recip);
            shift_reg <= shift;
            low_reg   <= req.dividend[13:0];
            div_reg   <= req.divisor;
        end
        if (mul_stage_reg) begin
            quo_reg <= 32'(prod_reg >> shift_reg);
        end
        if (sub_stage_reg) begin
            rem_reg <= low_reg - quo_reg[13:0] * div_reg;
        end
    end

endmodule

// ===== design/stp_decoder.sv =====
// Back end: decodes queued frames, keeps position/status registers and
// builds the result through the shared divider. Depends on stp_pkg.
`timescale 1ns / 1ps

module stp_decoder import stp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  frame_t       head,
    input  logic         empty,
    output logic         pop,
    output div_req_t     div_req,
    input  div_rsp_t     div_rsp,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_crc_ok,
    output logic [26:0]  m_latitude,
    output logic [26:0]  m_longitude,
    output logic [15:0]  m_altitude,
    output logic [7:0]   m_satellites,
    output logic         m_gps_fix,
    output logic [3:0]   m_hdop_level
);

    dec_state_t  state_reg, state_next;
    div_op_t     op_reg, op_next;
    logic        ok_reg, ok_next;
    logic        neg_reg, neg_next;
    logic [1:0]  hemi_reg, hemi_next;
    logic [15:0] frac_reg, frac_next;
    logic [9:0]  whole_reg, whole_next;
    logic [26:0] lat_out_reg, lat_out_next;

    logic [15:0] alt_reg, alt_next;
    logic [7:0]  sat_reg, sat_next;
    logic        fix_reg, fix_next;
    logic [3:0]  hdop_reg, hdop_next;
    logic [15:0] ns_reg, ns_next;
    logic [15:0] ew_reg, ew_next;
    logic [15:0] lat_dm_reg, lat_dm_next;
    logic [15:0] lat_fr_reg, lat_fr_next;
    logic [15:0] lon_dm_reg, lon_dm_next;
    logic [15:0] lon_fr_reg, lon_fr_next;

    logic        valid_reg, valid_next;
    logic        crc_reg, crc_next;
    logic [26:0] lat_res_reg, lat_res_next;
    logic [26:0] lon_res_reg, lon_res_next;
    logic [15:0] alt_res_reg, alt_res_next;
    logic [7:0]  sat_res_reg, sat_res_next;
    logic        fix_res_reg, fix_res_next;
    logic [3:0]  hdop_res_reg, hdop_res_next;

    logic [31:0] mag;
    logic [15:0] dm;
    logic [26:0] fixed_val;

    assign m_valid      = valid_reg;
    assign m_crc_ok     = crc_reg;
    assign m_latitude   = lat_res_reg;
    assign m_longitude  = lon_res_reg;
    assign m_altitude   = alt_res_reg;
    assign m_satellites = sat_res_reg;
    assign m_gps_fix    = fix_res_reg;
    assign m_hdop_level = hdop_res_reg;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        ok_next       = ok_reg;
        neg_next      = neg_reg;
        hemi_next     = hemi_reg;
        frac_next     = frac_reg;
        whole_next    = whole_reg;
        lat_out_next  = lat_out_reg;
        alt_next      = alt_reg;
        sat_next      = sat_reg;
        fix_next      = fix_reg;
        hdop_next     = hdop_reg;
        ns_next       = ns_reg;
        ew_next       = ew_reg;
        lat_dm_next   = lat_dm_reg;
        lat_fr_next   = lat_fr_reg;
        lon_dm_next   = lon_dm_reg;
        lon_fr_next   = lon_fr_reg;
        valid_next    = valid_reg && !m_ready;
        crc_next      = crc_reg;
        lat_res_next  = lat_res_reg;
        lon_res_next  = lon_res_reg;
        alt_res_next  = alt_res_reg;
        sat_res_next  = sat_res_reg;
        fix_res_next  = fix_res_reg;
        hdop_res_next = hdop_res_reg;
        pop           = 1'b0;
        div_req       = '0;
        mag           = head.data[31] ? 32'(32'd0 - head.data) : head.data;
        dm            = 16'(div_rsp.quotient[15:0] * 16'd100) + {2'd0, div_rsp.remainder};
        fixed_val     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!empty && !valid_reg) begin
                    pop        = 1'b1;
                    ok_next    = head.ok;
                    hemi_next  = head.data[31:30];
                    state_next = ST_FIX;
                    if (head.ok && head.prim == PRIM_DATA) begin
                        if (head.app[15:8] == 8'd0) begin
                            unique case (head.app[7:0])
                                HUB_ALT:    alt_next    = head.data[15:0];
                                HUB_LON_DM: lon_dm_next = head.data[15:0];
                                HUB_LON_FR: lon_fr_next = head.data[15:0];
                                HUB_LAT_DM: lat_dm_next = head.data[15:0];
                                HUB_LAT_FR: lat_fr_next = head.data[15:0];
                                HUB_EW:     ew_next     = head.data[15:0];
                                HUB_NS:     ns_next     = head.data[15:0];
                                HUB_STATUS: begin
                                    neg_next         = 1'b0;
                                    div_req.start    = 1'b1;
                                    div_req.dividend = {16'd0, head.data[15:0]};
                                    div_req.divisor  = DIV_100;
                                    op_next          = OP_ST100;
                                    state_next       = ST_WAIT;
                                end
                                default: ;
                            endcase
                        end else if (head.app[15:4] == APP_T2_HI) begin
                            neg_next         = head.data[31];
                            div_req.start    = 1'b1;
                            div_req.dividend = mag;
                            div_req.divisor  = DIV_100;
                            op_next          = OP_ST100;
                            state_next       = ST_WAIT;
                        end else if (head.app[15:4] == APP_ALT_HI) begin
                            alt_next = head.data[15:0];
                        end else if (head.app[15:4] == APP_POS_HI) begin
                            div_req.start    = 1'b1;
                            div_req.dividend = {2'd0, head.data[29:0]};
                            div_req.divisor  = DIV_10000;
                            op_next          = OP_PK10K;
                            state_next       = ST_WAIT;
                        end
                    end
                end
            end
            ST_FIX: begin
                div_req.start    = 1'b1;
                div_req.dividend = {16'd0, lat_dm_reg};
                div_req.divisor  = DIV_100;
                op_next          = OP_LAT100;
                state_next       = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_rsp.done) begin
                    unique case (op_reg)
                        OP_ST100: begin
                            sat_next = neg_reg ? 8'(8'd0 - div_rsp.remainder[7:0])
                                               : div_rsp.remainder[7:0];
                            div_req.start    = 1'b1;
                            div_req.dividend = div_rsp.quotient;
                            div_req.divisor  = DIV_10;
                            op_next          = OP_ST10;
                        end
                        OP_ST10: begin
                            hdop_next  = div_rsp.remainder[3:0];
                            fix_next   = div_rsp.quotient[0];
                            state_next = ST_FIX;
                        end
                        OP_PK10K: begin
                            frac_next        = {2'd0, div_rsp.remainder};
                            div_req.start    = 1'b1;
                            div_req.dividend = div_rsp.quotient;
                            div_req.divisor  = DIV_60;
                            op_next          = OP_PK60;
                        end
                        OP_PK60: begin
                            unique case (hemi_reg)
                                HEMI_N: begin
                                    lat_dm_next = dm;
                                    lat_fr_next = frac_reg;
                                    ns_next     = CODE_N;
                                end
                                HEMI_S: begin
                                    lat_dm_next = dm;
                                    lat_fr_next = frac_reg;
                                    ns_next     = CODE_S;
                                end
                                HEMI_E: begin
                                    lon_dm_next = dm;
                                    lon_fr_next = frac_reg;
                                    ew_next     = CODE_E;
                                end
                                default: begin
                                    lon_dm_next = dm;
                                    lon_fr_next = frac_reg;
                                    ew_next     = CODE_W;
                                end
                            endcase
                            state_next = ST_FIX;
                        end
                        OP_LAT100: begin
                            whole_next       = div_rsp.quotient[9:0];
                            div_req.start    = 1'b1;
                            div_req.dividend = 32'(div_rsp.remainder[6:0] * DEG_SCALE)
                                             + 32'(lat_fr_reg * 5'd10);
                            div_req.divisor  = DIV_60;
                            op_next          = OP_LAT60;
                        end
                        OP_LAT60: begin
                            lat_out_next     = to_fixed(ns_reg == CODE_N, whole_reg,
                                                        div_rsp.quotient);
                            div_req.start    = 1'b1;
                            div_req.dividend = {16'd0, lon_dm_reg};
                            div_req.divisor  = DIV_100;
                            op_next          = OP_LON100;
                        end
                        OP_LON100: begin
                            whole_next       = div_rsp.quotient[9:0];
                            div_req.start    = 1'b1;
                            div_req.dividend = 32'(div_rsp.remainder[6:0] * DEG_SCALE)
                                             + 32'(lon_fr_reg * 5'd10);
                            div_req.divisor  = DIV_60;
                            op_next          = OP_LON60;
                        end
                        OP_LON60: begin
                            fixed_val     = to_fixed(ew_reg == CODE_E, whole_reg,
                                                     div_rsp.quotient);
                            valid_next    = 1'b1;
                            crc_next      = ok_reg;
                            lat_res_next  = lat_out_reg;
                            lon_res_next  = fixed_val;
                            alt_res_next  = alt_reg;
                            sat_res_next  = sat_reg;
                            fix_res_next  = fix_reg;
                            hdop_res_next = hdop_reg;
                            state_next    = ST_IDLE;
                        end
                        default: ;
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            valid_reg  <= 1'b0;
            alt_reg    <= '0;
            sat_reg    <= '0;
            fix_reg    <= 1'b0;
            hdop_reg   <= '0;
            ns_reg     <= '0;
            ew_reg     <= '0;
            lat_dm_reg <= '0;
            lat_fr_reg <= '0;
            lon_dm_reg <= '0;
            lon_fr_reg <= '0;
        end else begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            alt_reg    <= alt_next;
            sat_reg    <= sat_next;
            fix_reg    <= fix_next;
            hdop_reg   <= hdop_next;
            ns_reg     <= ns_next;
            ew_reg     <= ew_next;
            lat_dm_reg <= lat_dm_next;
            lat_fr_reg <= lat_fr_next;
            lon_dm_reg <= lon_dm_next;
            lon_fr_reg <= lon_fr_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        ok_reg       <= ok_next;
        neg_reg      <= neg_next;
        hemi_reg     <= hemi_next;
        frac_reg     <= frac_next;
        whole_reg    <= whole_next;
        lat_out_reg  <= lat_out_next;
        crc_reg      <= crc_next;
        lat_res_reg  <= lat_res_next;
        lon_res_reg  <= lon_res_next;
        alt_res_reg  <= alt_res_next;
        sat_res_reg  <= sat_res_next;
        fix_res_reg  <= fix_res_next;
        hdop_res_reg <= hdop_res_next;
    end

endmodule

// ===== design/sport_telemetry_receiver.sv =====
// Top level of the telemetry receiver: front end, frame queue, decoder and
// divider. Depends on stp_pkg and all stp_* modules.
// The receiver takes one byte per cycle while s_ready is high. A completed frame
// enters a two-entry queue; the decoder takes it from the queue and presents its
// result after its constant divisions have run through the shared divider (four
// divisions per frame, six when the frame carries a status or packed position
// update). The next frame is taken from the queue only after the previous result
// transaction has been accepted. s_ready drops only while two frames wait in the
// queue.
`timescale 1ns / 1ps

module sport_telemetry_receiver import stp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_rx_byte,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_crc_ok,
    output logic [26:0]  m_latitude,
    output logic [26:0]  m_longitude,
    output logic [15:0]  m_altitude,
    output logic [7:0]   m_satellites,
    output logic         m_gps_fix,
    output logic [3:0]   m_hdop_level
);

    logic     push, pop, empty, full;
    frame_t   push_frame, head;
    div_req_t div_req;
    div_rsp_t div_rsp;

    assign s_ready = !full;

    stp_deframer u_deframer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_valid && s_ready),
        .byte_data  (s_rx_byte),
        .push       (push),
        .frame      (push_frame)
    );

    stp_frame_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    stp_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    stp_decoder u_decoder (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_crc_ok     (m_crc_ok),
        .m_latitude   (m_latitude),
        .m_longitude  (m_longitude),
        .m_altitude   (m_altitude),
        .m_satellites (m_satellites),
        .m_gps_fix    (m_gps_fix),
        .m_hdop_level (m_hdop_level)
    );

endmodule
